@@ src/lwf_pkg.sv @@
// Shared types and constants for the Laplacian window filter.
// Used by lwf_line_buffer and laplacian_window_filter; depends on nothing.
`default_nettype none

package lwf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int MAX_RADIUS = 3;
   localparam int SLOTS      = 2 * MAX_RADIUS;
   localparam int SIDE_MAX   = 2 * MAX_RADIUS + 1;

   localparam int PIX_W    = 8;
   localparam int COL_W    = 10;
   localparam int ROW_W    = 12;
   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 13;
   localparam int RAD_W    = 2;
   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int CSUM_W   = $clog2(SIDE_MAX * 255 + 1);
   localparam int TOT_W    = $clog2(SIDE_MAX * SIDE_MAX * 255 + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_RADIUS = 2'd2;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_value;
      logic             frame_start;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] edge_value;
      logic [ROW_W-1:0] centre_row;
      logic [COL_W-1:0] centre_col;
      logic             frame_last;
   } rsp_type;

   // line buffer access: read every bank at addr, write pixel into bank slot
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [COL_W-1:0]  addr;
      logic [PIX_W-1:0]  pixel;
   } lb_ctrl_type;

   typedef logic [SLOTS-1:0][PIX_W-1:0] lb_rows_type;

endpackage

`default_nettype wire

@@ src/laplacian_window_filter.sv @@
// Top level of the Laplacian window filter: counters, window column sums,
// response pipeline and register port. Depends on lwf_pkg and lwf_line_buffer.
//
// Usage:
//   req_*  : one grey pixel per item in raster order; frame_start on the
//            first pixel of a frame clears the row and column counters.
//   rsp_*  : one item per interior window centre with |Laplacian| clamped
//            to 255, the centre row/column and a last-of-frame flag.
//            Border centres produce no item.
//   csr_*  : register writes (0 width, 1 height, 2 radius), always ready;
//            write only while the block is idle.
// Path: the pixel that completes a window passes the stage 1, stage 2, stage 3
//   and output registers before its result shows on rsp_valid.
// Throughput: one pixel per cycle unless stalled; line buffer: six single-port
//   row banks of 1024 pixels, each read once, written at most once per pixel.
// Reset: registers go to 512 x 512, radius 1; counters and the pipeline
//   clear. Line buffer contents are not cleared and are only read after
//   being written within the frame.
// Stall: the output register holds while rsp_ready is low; the pipeline
//   keeps taking pixels until its stages fill, then req_ready drops.
`default_nettype none

module laplacian_window_filter (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire lwf_pkg::req_type            req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output lwf_pkg::rsp_type                 rsp_data,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [lwf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [lwf_pkg::CSR_DATA_W-1:0]    csr_data
);
   import lwf_pkg::*;

   // configuration
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [RAD_W-1:0]    radius_ff;
   logic [WIDTH_W-1:0]  w_sat;
   logic [HEIGHT_W-1:0] h_sat;
   logic [RAD_W-1:0]    rad_sat;
   logic [RAD_W:0]      twice_rad;

   // raster counters
   logic [COL_W-1:0]    col_ff, col_in, col_cur;
   logic [ROW_W-1:0]    row_ff, row_in, row_cur;
   logic [SLOT_W-1:0]   slot_ff, slot_in, slot_cur;
   logic [WIDTH_W-1:0]  col_inc;
   logic [HEIGHT_W-1:0] row_inc;
   logic                emit_cur, last_cur;

   // flow control
   logic accept, free1, free2, free3, out_en, mv12, mv23, load_out;

   // stage 1: pixel and line buffer read
   logic              v1_ff, v1_in;
   logic [PIX_W-1:0]  pix1_ff;
   logic [SLOT_W-1:0] slot1_ff;
   logic              emit1_ff, last1_ff;
   logic [ROW_W-1:0]  crow1_ff;
   logic [COL_W-1:0]  ccol1_ff;
   lb_ctrl_type       lb_ctrl;
   lb_rows_type       lb_rows;

   // stage 2: column shift line
   logic              v2_ff, v2_in;
   logic              emit2_ff, last2_ff;
   logic [ROW_W-1:0]  crow2_ff;
   logic [COL_W-1:0]  ccol2_ff;
   logic [CSUM_W-1:0] colsum_ff [SIDE_MAX];
   logic [PIX_W-1:0]  colmid_ff [SIDE_MAX];
   logic [CSUM_W-1:0] new_sum;
   logic [PIX_W-1:0]  new_mid;

   // stage 3: window total and weighted centre
   logic              v3_ff, v3_in;
   logic              last3_ff;
   logic [ROW_W-1:0]  crow3_ff;
   logic [COL_W-1:0]  ccol3_ff;
   logic [TOT_W-1:0]  total3_ff, total_in;
   logic [TOT_W-1:0]  prod3_ff, prod_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;
   logic [PIX_W-1:0]  edge_in;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_W'(512);
         height_ff <= HEIGHT_W'(512);
         radius_ff <= RAD_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   width_ff  <= csr_data[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT:  height_ff <= csr_data[HEIGHT_W-1:0];
            CSR_WINDOW_RADIUS: radius_ff <= csr_data[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) w_sat = WIDTH_W'(1);
      else if (width_ff > WIDTH_W'(MAX_WIDTH)) w_sat = WIDTH_W'(MAX_WIDTH);
      else w_sat = width_ff;

      if (height_ff == '0) h_sat = HEIGHT_W'(1);
      else if (height_ff > HEIGHT_W'(MAX_HEIGHT)) h_sat = HEIGHT_W'(MAX_HEIGHT);
      else h_sat = height_ff;

      if (radius_ff == '0) rad_sat = RAD_W'(1);
      else if (radius_ff > RAD_W'(MAX_RADIUS)) rad_sat = RAD_W'(MAX_RADIUS);
      else rad_sat = radius_ff;
   end

   assign twice_rad = {rad_sat, 1'b0};

   // ---------------------------------------------------------- flow control
   assign out_en   = !rsp_valid_ff || rsp_ready;
   assign free3    = !v3_ff || out_en;
   assign free2    = !v2_ff || !emit2_ff || free3;
   assign free1    = !v1_ff || free2;
   assign req_ready = free1;
   assign accept   = req_valid && free1;
   assign mv12     = v1_ff && free2;
   assign mv23     = v2_ff && emit2_ff && free3;
   assign load_out = v3_ff && out_en;

   assign v1_in        = accept || (v1_ff && !free2);
   assign v2_in        = mv12 || (v2_ff && !free2);
   assign v3_in        = mv23 || (v3_ff && !free3);
   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ready);

   // -------------------------------------------------------------- counters
   always_comb begin
      col_cur  = req_data.frame_start ? '0 : col_ff;
      row_cur  = req_data.frame_start ? '0 : row_ff;
      slot_cur = req_data.frame_start ? '0 : slot_ff;
      if ({1'b0, col_cur} >= w_sat) col_cur = '0;
      if ({1'b0, row_cur} >= h_sat) begin
         row_cur  = '0;
         slot_cur = '0;
      end

      col_inc = {1'b0, col_cur} + WIDTH_W'(1);
      row_inc = {1'b0, row_cur} + HEIGHT_W'(1);

      col_in  = col_inc[COL_W-1:0];
      row_in  = row_cur;
      slot_in = slot_cur;
      if (col_inc >= w_sat) begin
         col_in = '0;
         if (row_inc >= h_sat) begin
            row_in  = '0;
            slot_in = '0;
         end else begin
            row_in  = row_inc[ROW_W-1:0];
            slot_in = (slot_cur == SLOT_W'(SLOTS - 1)) ? '0 : slot_cur + SLOT_W'(1);
         end
      end

      emit_cur = (row_cur >= ROW_W'(twice_rad)) && (col_cur >= COL_W'(twice_rad));
      last_cur = (row_inc == h_sat) && (col_inc == w_sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   // --------------------------------------------------------------- stage 1
   always_comb begin
      lb_ctrl.en    = accept;
      lb_ctrl.slot  = slot_cur;
      lb_ctrl.addr  = col_cur;
      lb_ctrl.pixel = req_data.pixel_value;
   end

   lwf_line_buffer u_line_buffer (
      .clock   (clock),
      .ctrl    (lb_ctrl),
      .rd_data (lb_rows)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         pix1_ff  <= req_data.pixel_value;
         slot1_ff <= slot_cur;
         emit1_ff <= emit_cur;
         last1_ff <= last_cur;
         crow1_ff <= row_cur - ROW_W'(rad_sat);
         ccol1_ff <= col_cur - COL_W'(rad_sat);
      end
   end

   // --------------------------------------------------------------- stage 2
   // newest column: rows back 0 (this pixel) up to back 2R from the banks
   always_comb begin
      logic [PIX_W-1:0]  colv [SLOTS+1];
      logic [SLOT_W:0]   idx;
      colv[0] = pix1_ff;
      for (int b = 1; b <= SLOTS; b++) begin
         idx = {1'b0, slot1_ff} + (SLOT_W+1)'(SLOTS - b);
         if (idx >= (SLOT_W+1)'(SLOTS)) idx = idx - (SLOT_W+1)'(SLOTS);
         colv[b] = lb_rows[idx[SLOT_W-1:0]];
      end
      new_sum = '0;
      new_mid = '0;
      for (int b = 0; b <= SLOTS; b++) begin
         if (b <= int'(twice_rad)) new_sum = new_sum + CSUM_W'(colv[b]);
         if (b == int'(rad_sat)) new_mid = colv[b];
      end
   end

   always_ff @(posedge clock) begin
      if (mv12) begin
         colsum_ff[0] <= new_sum;
         colmid_ff[0] <= new_mid;
         for (int a = 1; a < SIDE_MAX; a++) begin
            colsum_ff[a] <= colsum_ff[a-1];
            colmid_ff[a] <= colmid_ff[a-1];
         end
         emit2_ff <= emit1_ff;
         last2_ff <= last1_ff;
         crow2_ff <= crow1_ff;
         ccol2_ff <= ccol1_ff;
      end
   end

   // --------------------------------------------------------------- stage 3
   always_comb begin
      logic [PIX_W-1:0]     centre;
      logic [RAD_W:0]       side;
      logic [2*RAD_W+1:0]   side_sq;
      total_in = '0;
      centre   = '0;
      for (int a = 0; a < SIDE_MAX; a++) begin
         if (a <= int'(twice_rad)) total_in = total_in + TOT_W'(colsum_ff[a]);
         if (a == int'(rad_sat)) centre = colmid_ff[a];
      end
      side    = {rad_sat, 1'b1};
      side_sq = (2*RAD_W+2)'(side) * (2*RAD_W+2)'(side);
      prod_in = TOT_W'(centre) * TOT_W'(side_sq);
   end

   always_ff @(posedge clock) begin
      if (mv23) begin
         total3_ff <= total_in;
         prod3_ff  <= prod_in;
         last3_ff  <= last2_ff;
         crow3_ff  <= crow2_ff;
         ccol3_ff  <= ccol2_ff;
      end
   end

   // ---------------------------------------------------------------- output
   always_comb begin
      logic signed [TOT_W:0] diff;
      logic        [TOT_W:0] mag;
      diff = $signed({1'b0, prod3_ff}) - $signed({1'b0, total3_ff});
      mag  = diff[TOT_W] ? (TOT_W+1)'(-diff) : (TOT_W+1)'(diff);
      edge_in = (mag > (TOT_W+1)'(255)) ? PIX_W'(255) : mag[PIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ff.edge_value <= edge_in;
         rsp_ff.centre_row <= crow3_ff;
         rsp_ff.centre_col <= ccol3_ff;
         rsp_ff.frame_last <= last3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ src/lwf_line_buffer.sv @@
// Line buffer of the Laplacian window filter: one row bank per slot.
// Depends on lwf_pkg.
`default_nettype none

module lwf_line_buffer (
   input  wire                       clock,
   input  wire lwf_pkg::lb_ctrl_type ctrl,
   output lwf_pkg::lb_rows_type      rd_data
);
   import lwf_pkg::*;

   logic [PIX_W-1:0] rd_data_ff [SLOTS];

   for (genvar s = 0; s < SLOTS; s++) begin : g_bank
      logic [PIX_W-1:0] mem [MAX_WIDTH];

      // read returns the old entry when the same address is written
      always_ff @(posedge clock) begin
         if (ctrl.en) begin
            rd_data_ff[s] <= mem[ctrl.addr];
            if (ctrl.slot == SLOT_W'(s)) begin
               mem[ctrl.addr] <= ctrl.pixel;
            end
         end
      end
   end

   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         rd_data[s] = rd_data_ff[s];
      end
   end

endmodule

`default_nettype wire

@@ tb/laplacian_window_filter_test.sv @@
// Self-checking testbench for laplacian_window_filter: drives pixel frames, register
// writes and output back-pressure, and checks every result against a local Laplacian
// predictor. Depends on lwf_pkg and the laplacian_window_filter RTL.
module laplacian_window_filter_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lwf_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 400;

   typedef enum logic [1:0] {TEX_NOISE, TEX_FLAT, TEX_EXTREME} texture_type;

   class laplacian_scoreboard;
      logic [WIDTH_W-1:0]  width_reg;
      logic [HEIGHT_W-1:0] height_reg;
      logic [RAD_W-1:0]    radius_reg;
      logic [PIX_W-1:0]    line_store [SLOTS][MAX_WIDTH];
      logic [PIX_W-1:0]    window [SIDE_MAX][SIDE_MAX];
      int                  col_pos;
      int                  row_pos;
      rsp_type             edge_queue [$];
      int                  errors;

      function new();
         width_reg  = WIDTH_W'(512);
         height_reg = HEIGHT_W'(512);
         radius_reg = RAD_W'(1);
         foreach (line_store[s, a]) line_store[s][a] = '0;
         foreach (window[k, j]) window[k][j] = '0;
         col_pos = 0;
         row_pos = 0;
         errors  = 0;
      endfunction

      function int clamp(int v, int lo, int hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_IMAGE_WIDTH:   width_reg  = data[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT:  height_reg = data[HEIGHT_W-1:0];
            CSR_WINDOW_RADIUS: radius_reg = data[RAD_W-1:0];
            default: ;
         endcase
      endfunction

      // advance the raster position by one pixel and queue the response it completes
      function void take_pixel(req_type px);
         int w, h, rad, side, slot_now, r, c, k, j, total, centre, resp;
         rsp_type res;
         w    = clamp(width_reg, 1, MAX_WIDTH);
         h    = clamp(height_reg, 1, MAX_HEIGHT);
         rad  = clamp(radius_reg, 1, MAX_RADIUS);
         side = 2 * rad + 1;
         if (px.frame_start) begin
            col_pos = 0;
            row_pos = 0;
         end
         if (col_pos >= w) col_pos = 0;
         if (row_pos >= h) row_pos = 0;
         r = row_pos;
         c = col_pos;
         slot_now = r % SLOTS;
         for (k = 0; k < side; k++)
            for (j = 0; j + 1 < side; j++)
               window[k][j] = window[k][j+1];
         for (k = 0; k < 2 * rad; k++)
            window[k][2*rad] = line_store[(slot_now + SLOTS - (2 * rad - k)) % SLOTS][c];
         window[2*rad][2*rad] = px.pixel_value;
         line_store[slot_now][c] = px.pixel_value;
         if (r >= 2 * rad && c >= 2 * rad) begin
            total = 0;
            for (k = 0; k < side; k++)
               for (j = 0; j < side; j++)
                  total += window[k][j];
            centre = window[rad][rad];
            resp = side * side * centre - total;
            if (resp < 0) resp = -resp;
            if (resp > 255) resp = 255;
            res.edge_value = resp[PIX_W-1:0];
            res.centre_row = ROW_W'(r - rad);
            res.centre_col = COL_W'(c - rad);
            res.frame_last = (r + 1 == h) && (c + 1 == w);
            edge_queue.push_back(res);
         end
         c++;
         if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
         end
         col_pos = c;
         row_pos = r;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (edge_queue.size() == 0) begin
            $error("result with nothing expected: row %0d col %0d value %0d",
                   got.centre_row, got.centre_col, got.edge_value);
            errors++;
            return;
         end
         want = edge_queue.pop_front();
         if (got.edge_value !== want.edge_value) begin
            $error("edge_value expected %0d got %0d", want.edge_value, got.edge_value);
            errors++;
         end
         if (got.centre_row !== want.centre_row) begin
            $error("centre_row expected %0d got %0d", want.centre_row, got.centre_row);
            errors++;
         end
         if (got.centre_col !== want.centre_col) begin
            $error("centre_col expected %0d got %0d", want.centre_col, got.centre_col);
            errors++;
         end
         if (got.frame_last !== want.frame_last) begin
            $error("frame_last expected %0d got %0d", want.frame_last, got.frame_last);
            errors++;
         end
      endfunction

      function int pending();
         return edge_queue.size();
      endfunction

      function void report_leftover();
         if (edge_queue.size() != 0) begin
            $error("%0d expected results never arrived", edge_queue.size());
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   laplacian_scoreboard sb;
   int  send_idle_pct;
   int  recv_stall_pct;
   bit  hold_req;
   int  pixels_sent;
   int  cycle_count = 0;

   laplacian_window_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_register(csr_index, csr_data);
         if (req_valid && req_ready) sb.take_pixel(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   function automatic logic [PIX_W-1:0] pick_pixel(texture_type tex, logic [PIX_W-1:0] base);
      case (tex)
         TEX_FLAT:    return base + PIX_W'($urandom_range(0, 3));
         TEX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         default:     return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after the item is taken
   task automatic send_pixel(input req_type px);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      pixels_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // wait until every expected result is in and the pipeline has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input int unsigned w, input int unsigned h, input int unsigned rad);
      settle();
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_WINDOW_RADIUS, rad);
   endtask

   // 3x3 frame with one value at the centre and another around it
   task automatic send_grid(input logic [PIX_W-1:0] centre, input logic [PIX_W-1:0] ring,
                            input logic first_mark);
      req_type px;
      int i;
      for (i = 0; i < 9; i++) begin
         px.pixel_value = (i == 4) ? centre : ring;
         px.frame_start = (i == 0) ? first_mark : 1'b0;
         send_pixel(px);
      end
   endtask

   // frames of random texture; the first item always restarts the frame
   task automatic stream_pixels(input int count, input int frame_pixels);
      req_type     px;
      texture_type tex;
      logic [PIX_W-1:0] base;
      int i;
      tex  = TEX_NOISE;
      base = '0;
      for (i = 0; i < count; i++) begin
         if (i % frame_pixels == 0) begin
            tex  = texture_type'($urandom_range(0, 2));
            base = PIX_W'($urandom_range(0, 252));
         end
         px.pixel_value = pick_pixel(tex, base);
         if (i == 0) px.frame_start = 1'b1;
         else if (i % frame_pixels == 0) px.frame_start = 1'($urandom_range(0, 1));
         else px.frame_start = ($urandom_range(0, 199) == 0);
         send_pixel(px);
      end
   endtask

   task automatic random_phase();
      int rad, w, h;
      rad = $urandom_range(1, MAX_RADIUS);
      w   = $urandom_range(2 * rad + 1, 2 * rad + 8);
      h   = $urandom_range(2 * rad + 1, 2 * rad + 4);
      configure(w, h, rad);
      stream_pixels(w * h * $urandom_range(1, 2), w * h);
   endtask

   task automatic random_run(input int target);
      int start;
      start = pixels_sent;
      while (pixels_sent - start < target) random_phase();
   endtask

   initial begin
      sb             = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      hold_req       = 1'b0;
      pixels_sent    = 0;
      send_idle_pct  = 36;
      recv_stall_pct = 74;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: unused register index, out-of-range radius, saturating and small
      // responses, and a frame that follows without a start mark
      write_reg(CSR_SPARE, 13'h1FFF);
      configure(3, 3, 0);
      send_grid(8'hFF, 8'h00, 1'b1);
      send_grid(8'h00, 8'hFF, 1'b0);
      send_grid(8'd12, 8'd10, 1'b1);

      // image narrower than the window, then zero-sized registers
      configure(4, 5, 2);
      stream_pixels(20, 20);
      configure(0, 0, 0);
      stream_pixels(6, 1);
      random_run(100);

      send_idle_pct  = 74;
      recv_stall_pct = 36;
      // height beyond range, cut short by the next phase
      configure(3, 8191, 1);
      stream_pixels(40, 3 * MAX_HEIGHT);
      random_run(100);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      configure(16, 8, 1);
      hold_req = 1'b1;
      stream_pixels(128, 128);
      configure(5, 4096, 2);
      stream_pixels(40, 5 * 4096);
      random_run(80);

      settle();
      sb.report_leftover();
      if (sb.errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
